### hw/rtl/gate_netlist_evaluator_defines.svh
// Assertion macros used by the gate netlist evaluator datapath.
`ifndef GATE_NETLIST_EVALUATOR_DEFINES_SVH
`define GATE_NETLIST_EVALUATOR_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define GNE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define GNE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/gne_pkg.sv
// Types, constants and codes of the gate netlist evaluator.
`default_nettype none
package gne_pkg;

    localparam int MAX_GATES = 128;
    localparam int GATE_W    = $clog2(MAX_GATES);
    localparam int COUNT_W   = $clog2(MAX_GATES + 1);
    localparam int SEL_W     = 8;
    localparam int PASS_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;

    localparam logic [PASS_W-1:0] PASS_LIMIT_RESET = 4'd10;
    localparam logic [SEL_W-1:0]  SEL_NONE         = 8'd0;
    localparam logic [SEL_W-1:0]  SEL_VAR_LAST     = 8'd4;
    localparam logic [SEL_W-1:0]  SEL_GATE_BASE    = 8'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_GATE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESULT_GATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_LIMIT  = 2'd2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [2:0] {
        K_NOT    = 3'd0,
        K_AND    = 3'd1,
        K_NAND   = 3'd2,
        K_OR     = 3'd3,
        K_NOR    = 3'd4,
        K_XOR    = 3'd5,
        K_XNOR   = 3'd6,
        K_RESULT = 3'd7
    } t_kind;

    typedef struct packed {
        logic             opcode;
        logic [6:0]       gate_index;
        logic [2:0]       gate_kind;
        logic [SEL_W-1:0] source_first;
        logic [SEL_W-1:0] source_second;
        logic             var_a;
        logic             var_b;
        logic             var_c;
        logic             var_d;
    } t_in_word;

    typedef struct packed {
        logic out_value;
        logic resolved;
    } t_out_word;

    typedef struct packed {
        t_kind            kind;
        logic [SEL_W-1:0] src1;
        logic [SEL_W-1:0] src2;
    } t_entry;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic used_zero;
        logic limit_zero;
        logic last_entry;
        logic pass_last;
        logic done_now;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

### hw/rtl/gne_ctrl.sv
// Controller state machine of the gate netlist evaluator.
`default_nettype none
module gne_ctrl import gne_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_opcode,
    output logic      o_in_stall,
    input  t_stat     i_stat,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SWEEP  = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   in_acc;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_opcode == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        if (i_stat.used_zero || i_stat.limit_zero) begin
                            n_state = S_FINISH;
                        end else begin
                            n_state = S_SWEEP;
                        end
                    end
                end
            end
            S_SWEEP: begin
                o_cmd.step = 1'b1;
                if (i_stat.done_now || (i_stat.last_entry && i_stat.pass_last)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/gne_datapath.sv
// Datapath: gate table, marks and values, configuration and output register.
`default_nettype none
`include "gate_netlist_evaluator_defines.svh"
module gne_datapath import gne_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  t_in_word                  i_in_word,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  t_cmd                      i_cmd,
    output t_stat                     o_stat,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_word                 o_out_word
);

    logic [COUNT_W-1:0]   r_count;
    logic [GATE_W-1:0]    r_result;
    logic [PASS_W-1:0]    r_limit;
    logic [PASS_W-1:0]    r_pass;
    logic [GATE_W-1:0]    r_ptr;
    logic [3:0]           r_vars;
    logic [MAX_GATES-1:0] r_mark;
    logic [MAX_GATES-1:0] r_val;
    t_entry               mem [MAX_GATES];
    t_entry               r_entry;
    logic                 r_out_valid;
    t_out_word            r_out;

    logic [COUNT_W-1:0] used;
    logic [GATE_W-1:0]  rd_addr;
    logic               rd_en;
    logic [GATE_W-1:0]  ptr_next;
    logic               known1, known2, x, y, r, single, wr, res_in, resolved;
    logic [SEL_W-1:0]   g1, g2;

    assign o_cfg_ready = 1'b1;
    assign used = (r_count > COUNT_W'(MAX_GATES)) ? COUNT_W'(MAX_GATES) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_result <= '0;
            r_limit  <= PASS_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GATE_COUNT:  r_count  <= i_cfg_data[COUNT_W-1:0];
                CFG_RESULT_GATE: r_result <= i_cfg_data[GATE_W-1:0];
                CFG_PASS_LIMIT:  r_limit  <= i_cfg_data[PASS_W-1:0];
                default: ;
            endcase
        end
    end

    // source lookup; gate g is selector 5+g
    assign g1 = r_entry.src1 - SEL_GATE_BASE;
    assign g2 = r_entry.src2 - SEL_GATE_BASE;

    always_comb begin
        known1 = 1'b0;
        x      = 1'b0;
        if (r_entry.src1 == SEL_NONE) begin
            known1 = 1'b0;
        end else if (r_entry.src1 <= SEL_VAR_LAST) begin
            known1 = 1'b1;
            x      = r_vars[r_entry.src1[1:0] - 2'd1];
        end else if (g1 < SEL_W'(used)) begin
            known1 = r_mark[g1[GATE_W-1:0]];
            x      = r_val[g1[GATE_W-1:0]];
        end
    end

    always_comb begin
        known2 = 1'b0;
        y      = 1'b0;
        if (r_entry.src2 == SEL_NONE) begin
            known2 = 1'b0;
        end else if (r_entry.src2 <= SEL_VAR_LAST) begin
            known2 = 1'b1;
            y      = r_vars[r_entry.src2[1:0] - 2'd1];
        end else if (g2 < SEL_W'(used)) begin
            known2 = r_mark[g2[GATE_W-1:0]];
            y      = r_val[g2[GATE_W-1:0]];
        end
    end

    always_comb begin
        case (r_entry.kind)
            K_NOT:    r = ~x;
            K_AND:    r = x & y;
            K_NAND:   r = ~(x & y);
            K_OR:     r = x | y;
            K_NOR:    r = ~(x | y);
            K_XOR:    r = x ^ y;
            K_XNOR:   r = ~(x ^ y);
            K_RESULT: r = x;
            default:  r = x;
        endcase
    end

    assign single = (r_entry.kind == K_NOT) || (r_entry.kind == K_RESULT);
    assign wr     = i_cmd.step && !r_mark[r_ptr] && known1 && (single || known2);

    assign res_in   = {1'b0, r_result} < used;
    assign resolved = res_in && r_mark[r_result];

    assign o_stat.used_zero  = (used == '0);
    assign o_stat.limit_zero = (r_limit == '0);
    assign o_stat.last_entry = ({1'b0, r_ptr} == used - COUNT_W'(1));
    assign o_stat.pass_last  = ({1'b0, r_pass} + (PASS_W+1)'(1)) >= {1'b0, r_limit};
    assign o_stat.done_now   = res_in && (r_mark[r_result] || (wr && (r_ptr == r_result)));
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    assign ptr_next = o_stat.last_entry ? '0 : r_ptr + GATE_W'(1);
    assign rd_en    = i_cmd.start || i_cmd.step;
    assign rd_addr  = i_cmd.start ? '0 : ptr_next;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            mem[i_in_word.gate_index] <= '{kind: t_kind'(i_in_word.gate_kind),
                                           src1: i_in_word.source_first,
                                           src2: i_in_word.source_second};
        end
        if (rd_en) begin
            r_entry <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= '0;
            r_pass <= '0;
            r_ptr  <= '0;
        end else if (i_cmd.start) begin
            r_mark <= '0;
            r_pass <= '0;
            r_ptr  <= '0;
        end else if (i_cmd.step) begin
            r_ptr <= ptr_next;
            if (o_stat.last_entry) begin
                r_pass <= r_pass + PASS_W'(1);
            end
            if (wr) begin
                r_mark[r_ptr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_vars <= {i_in_word.var_d, i_in_word.var_c, i_in_word.var_b, i_in_word.var_a};
        end
        if (wr) begin
            r_val[r_ptr] <= r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.resolved  <= resolved;
            r_out.out_value <= resolved && r_val[r_result];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `GNE_ASSERT_NXT(a_marks_cleared, i_cmd.start, r_mark == '0, "marks not cleared at start")
    `GNE_ASSERT_NXT(a_marks_sticky, !i_cmd.start, (r_mark & $past(r_mark)) == $past(r_mark),
        "computed mark lost during evaluation")
    `GNE_ASSERT_IMP(a_out_from_finish, $rose(r_out_valid), $past(i_cmd.finish),
        "output word without finish")
    `GNE_ASSERT_IMP(a_finish_free, i_cmd.finish, o_stat.out_free, "finish overwrote held word")

endmodule
`default_nettype wire

### hw/rtl/gate_netlist_evaluator.sv
// Top level of the gate netlist evaluator: controller plus datapath.
//
// Input channel (i_in_valid / o_in_stall, word i_in_word): a load word writes
// one table entry and gives no result. An evaluate word clears the computed
// marks and sweeps entries 0..gate_count-1 (gate_count capped at 128), one
// entry per cycle (the single read port of the gate table), for up to
// pass_limit passes, stopping as soon as the result gate is computed. It then
// gives one output word; no new word is taken until the result is registered.
// Output channel (o_out_valid / i_out_stall, word o_out_word): a one-word
// output register; a load may be accepted while a result waits there, and an
// evaluate that finishes while the word is still stalled waits for it to go.
// Configuration (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data): ready
// is always high; index 0 gate_count, 1 result_gate, 2 pass_limit.
// Reset (i_rst_n low, synchronous): controller idle, output empty, marks
// cleared, gate_count 0, result_gate 0, pass_limit 10. Table contents are
// not reset and must be loaded before use.
`default_nettype none
module gate_netlist_evaluator import gne_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  t_in_word                  i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_word                 o_out_word,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    gne_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_word.opcode),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gne_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
`default_nettype wire
